@@ hw/rtl/ase_pkg.sv @@
`default_nettype none
package ase_pkg;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_CSI = 8'h5b;
  localparam logic [7:0] CH_OSC = 8'h5d;
  localparam logic [7:0] CH_DCS = 8'h50;
  localparam logic [7:0] CH_SOS = 8'h58;
  localparam logic [7:0] CH_PM  = 8'h5e;
  localparam logic [7:0] CH_APC = 8'h5f;
  localparam logic [7:0] CH_ST  = 8'h5c;
  localparam logic [7:0] INT_LO = 8'h20;
  localparam logic [7:0] INT_HI = 8'h2f;
  localparam logic [7:0] PAR_HI = 8'h3f;
  localparam logic [7:0] FIN_LO = 8'h30;
  localparam logic [7:0] CSF_LO = 8'h40;
  localparam logic [7:0] FIN_HI = 8'h7e;

  typedef enum logic [2:0] {
    PH_GROUND, PH_ESC, PH_CSI, PH_OSC, PH_OSC_ESC, PH_STR, PH_STR_ESC, PH_INTER
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_FEED, ST_EMIT_RD, ST_EMIT_WR, ST_MARK, ST_FLUSH
  } ctl_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       text_end;
    logic       seq_overflow;
  } res_t;

  typedef struct packed {
    phase_t nxt;
    logic   fin;
    logic   bad;
  } dec_t;

  // One step of the sequence parser for a phase other than ground.
  function automatic dec_t feed_dec(input phase_t ph, input logic [7:0] b);
    dec_t d;
    d.nxt = ph;
    d.fin = 1'b0;
    d.bad = 1'b0;
    unique case (ph)
      PH_ESC: begin
        if (b == CH_CSI) d.nxt = PH_CSI;
        else if (b == CH_OSC) d.nxt = PH_OSC;
        else if (b == CH_DCS || b == CH_SOS || b == CH_PM || b == CH_APC) d.nxt = PH_STR;
        else if (b >= INT_LO && b <= INT_HI) d.nxt = PH_INTER;
        else if (b >= FIN_LO && b <= FIN_HI) d.fin = 1'b1;
        else d.bad = 1'b1;
      end
      PH_CSI: begin
        if (b >= INT_LO && b <= PAR_HI) d.nxt = PH_CSI;
        else if (b >= CSF_LO && b <= FIN_HI) d.fin = 1'b1;
        else d.bad = 1'b1;
      end
      PH_OSC: begin
        if (b == CH_BEL) d.fin = 1'b1;
        else if (b == CH_ESC) d.nxt = PH_OSC_ESC;
      end
      PH_OSC_ESC: begin
        if (b == CH_ST || b == CH_BEL) d.fin = 1'b1;
        else if (b != CH_ESC) d.nxt = PH_OSC;
      end
      PH_STR: begin
        if (b == CH_ESC) d.nxt = PH_STR_ESC;
      end
      PH_STR_ESC: begin
        if (b == CH_ST) d.fin = 1'b1;
        else if (b != CH_ESC) d.nxt = PH_STR;
      end
      PH_INTER: begin
        if (b >= INT_LO && b <= INT_HI) d.nxt = PH_INTER;
        else if (b >= FIN_LO && b <= FIN_HI) d.fin = 1'b1;
        else d.bad = 1'b1;
      end
      PH_GROUND: d.bad = 1'b1;
      default: d.bad = 1'b1;
    endcase
    if (d.fin) d.nxt = PH_GROUND;
    return d;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ase_if.sv @@
`default_nettype none
interface ase_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;
  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

interface ase_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last_of_run;
  logic       text_end;
  logic       seq_overflow;
  modport source (output valid, out_byte, has_byte, last_of_run, text_end, seq_overflow,
                  input ready);
  modport sink   (input valid, out_byte, has_byte, last_of_run, text_end, seq_overflow,
                  output ready);
endinterface

interface ase_cfg_if;
  logic valid;
  logic ready;
  logic pass_seq;
  modport source (output valid, pass_seq, input ready);
  modport sink   (input valid, pass_seq, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ase_ram.sv @@
`default_nettype none
module ase_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/ansi_escape_sanitizer_unit.sv @@
// A plain byte goes through the steps accept, read, parse, end check and flush;
//   a new byte is taken only in idle, once the last one is through. A replayed
//   byte takes a read and a parse, a byte of a passed sequence a read and a write,
//   all set by the single read port of the byte memory.
// Reset (rst, synchronous, active high): parser to ground, base, read and write
//   pointers to zero, pass flag to 0, output empty. The byte memory needs no clearing.
`default_nettype none
module ansi_escape_sanitizer_unit #(
  parameter int MAX_SEQ = 32
) (
  input wire logic clk,
  input wire logic rst,
  ase_in_if.sink   in_ch,
  ase_out_if.source out_ch,
  ase_cfg_if.sink  cfg
);
  import ase_pkg::*;

  // The memory is a ring: [base, rd) is the pending sequence,
  // [rd, wr) are bytes still to be parsed (new byte or replay).
  localparam int AW    = $clog2(MAX_SEQ + 1);
  localparam int DEPTH = 2 ** AW;

  ctl_t   state, state_next;
  phase_t phase, phase_next;
  logic [AW-1:0] base, base_next;
  logic [AW-1:0] rd, rd_next;
  logic [AW-1:0] wr, wr_next;
  logic [AW-1:0] eptr, eptr_next;
  logic [AW-1:0] cnt;
  logic eot, eot_next;
  logic allow;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // One result is held back so the last one of a run can be flagged.
  res_t hold, push_r, out_r;
  logic hold_v, out_v, out_last;
  logic push, flush, can_push;
  dec_t dec;
  logic is_ctrl;

  ase_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr),
    .wdata (in_ch.in_byte),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = (state == ST_IDLE);

  assign can_push = !hold_v || !out_v || out_ch.ready;
  assign cnt      = rd - base;
  assign dec      = feed_dec(phase, mem_rdata);
  assign is_ctrl  = (mem_rdata == CH_DEL) ||
                    (mem_rdata < CH_SP && mem_rdata != CH_LF && mem_rdata != CH_TAB);

  always_comb begin
    state_next = state;
    phase_next = phase;
    base_next  = base;
    rd_next    = rd;
    wr_next    = wr;
    eptr_next  = eptr;
    eot_next   = eot;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = rd;
    push       = 1'b0;
    push_r     = '0;
    flush      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          eot_next = in_ch.end_of_text;
          if (!in_ch.end_of_text) begin
            mem_we  = 1'b1;
            wr_next = wr + AW'(1);
          end
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (rd != wr) begin
          mem_re     = 1'b1;
          state_next = ST_FEED;
        end else if (eot && phase != PH_GROUND) begin
          // unterminated at end of text: drop the ESC, replay the rest
          rd_next    = base + AW'(1);
          phase_next = PH_GROUND;
        end else begin
          state_next = eot ? ST_MARK : ST_FLUSH;
        end
      end
      ST_FEED: begin
        if (phase == PH_GROUND) begin
          if (mem_rdata == CH_ESC) begin
            base_next  = rd;
            rd_next    = rd + AW'(1);
            phase_next = PH_ESC;
            state_next = ST_RUN;
          end else if (is_ctrl) begin
            rd_next    = rd + AW'(1);
            state_next = ST_RUN;
          end else if (can_push) begin
            push            = 1'b1;
            push_r.out_byte = mem_rdata;
            push_r.has_byte = 1'b1;
            rd_next         = rd + AW'(1);
            state_next      = ST_RUN;
          end
        end else if (cnt >= AW'(MAX_SEQ)) begin
          // overlong: buffer and this byte are dropped
          if (can_push) begin
            push                = 1'b1;
            push_r.seq_overflow = 1'b1;
            rd_next             = rd + AW'(1);
            phase_next          = PH_GROUND;
            state_next          = ST_RUN;
          end
        end else if (dec.bad) begin
          rd_next    = base + AW'(1);
          phase_next = PH_GROUND;
          state_next = ST_RUN;
        end else begin
          rd_next    = rd + AW'(1);
          phase_next = dec.nxt;
          if (dec.fin && allow) begin
            eptr_next  = base;
            state_next = ST_EMIT_RD;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_EMIT_RD: begin
        if (eptr == rd) begin
          state_next = ST_RUN;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = eptr;
          state_next = ST_EMIT_WR;
        end
      end
      ST_EMIT_WR: begin
        if (can_push) begin
          push            = 1'b1;
          push_r.out_byte = mem_rdata;
          push_r.has_byte = 1'b1;
          eptr_next       = eptr + AW'(1);
          state_next      = ST_EMIT_RD;
        end
      end
      ST_MARK: begin
        if (can_push) begin
          push            = 1'b1;
          push_r.text_end = 1'b1;
          state_next      = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!hold_v) begin
          state_next = ST_IDLE;
        end else if (!out_v || out_ch.ready) begin
          flush      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_GROUND;
      base  <= '0;
      rd    <= '0;
      wr    <= '0;
      eot   <= 1'b0;
      allow <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      base  <= base_next;
      rd    <= rd_next;
      wr    <= wr_next;
      eot   <= eot_next;
      if (cfg.valid) allow <= cfg.pass_seq;
    end
  end

  always_ff @(posedge clk) begin
    eptr <= eptr_next;
  end

  // Output stage: hold register feeds the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      out_v  <= 1'b0;
    end else if (push) begin
      if (hold_v) begin
        out_v <= 1'b1;
      end else if (out_ch.ready) begin
        out_v <= 1'b0;
      end
      hold_v <= 1'b1;
    end else if (flush) begin
      out_v  <= 1'b1;
      hold_v <= 1'b0;
    end else if (out_ch.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hold <= push_r;
      if (hold_v) begin
        out_r    <= hold;
        out_last <= 1'b0;
      end
    end else if (flush) begin
      out_r    <= hold;
      out_last <= 1'b1;
    end
  end

  assign out_ch.valid        = out_v;
  assign out_ch.out_byte     = out_r.out_byte;
  assign out_ch.has_byte     = out_r.has_byte;
  assign out_ch.text_end     = out_r.text_end;
  assign out_ch.seq_overflow = out_r.seq_overflow;
  assign out_ch.last_of_run  = out_last;

endmodule
`default_nettype wire

@@ hw/rtl/ase_chk.sv @@
`default_nettype none
module ase_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       has_byte,
  input wire logic       last_of_run,
  input wire logic       text_end,
  input wire logic       seq_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("stalled output transaction changed");

  a_text_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_end |-> !has_byte && last_of_run && !seq_overflow)
    else $error("text end marker malformed");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && seq_overflow |-> !has_byte && !text_end)
    else $error("overflow marker carries a byte");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> out_byte == 8'h00)
    else $error("marker transaction has nonzero byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind ansi_escape_sanitizer_unit ase_chk u_ase_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .has_byte     (out_ch.has_byte),
  .last_of_run  (out_ch.last_of_run),
  .text_end     (out_ch.text_end),
  .seq_overflow (out_ch.seq_overflow)
);
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import ase_pkg::*;

  localparam int SEQ_DEPTH   = 32;       // buffer depth of the unit under test
  localparam int CYCLE_LIMIT = 1000000;  // hard stop, far beyond a slow correct run
  localparam int SETTLE      = 400;      // covers the longest replay after the last result
  localparam int HOLD_OFF    = 300;      // long receiver stall to fill the unit

  typedef struct {
    logic [7:0] data;
    bit         eot;
  } text_item_t;

  typedef struct {
    logic [7:0] data;
    bit         has;
    bit         last;
    bit         te;
    bit         ov;
  } clean_res_t;

  logic clk;
  logic rst;

  ase_in_if  in_ch ();
  ase_out_if out_ch ();
  ase_cfg_if cfg ();

  ansi_escape_sanitizer_unit #(.MAX_SEQ(SEQ_DEPTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // Stimulus still to be offered, and filtered output still owed by the unit.
  text_item_t text_q[$];
  clean_res_t clean_q[$];

  // Shadow of the filter state.
  phase_t     shadow_phase;
  logic [7:0] shadow_seq[$];
  bit         shadow_allow;
  clean_res_t run_res[$];

  int  errors;
  int  accepted;
  int  cycles;
  bit  no_gaps;       // burst mode: sender and receiver never idle
  bit  pressure_done;

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.pass_seq = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  task automatic add_res(input logic [7:0] d, input bit h, input bit t, input bit o);
    clean_res_t r;
    r.data = d;
    r.has = h;
    r.last = 1'b0;
    r.te = t;
    r.ov = o;
    run_res.push_back(r);
  endtask

  // Completed sequence: passed whole or dropped by the allow flag.
  task automatic close_seq();
    if (shadow_allow) begin
      foreach (shadow_seq[i]) add_res(shadow_seq[i], 1'b1, 1'b0, 1'b0);
    end
    shadow_seq.delete();
    shadow_phase = PH_GROUND;
  endtask

  task automatic parse_byte(input logic [7:0] b, output bit bad);
    bad = 1'b0;
    if (shadow_phase == PH_GROUND) begin
      if (b == CH_ESC) begin
        shadow_seq.delete();
        shadow_seq.push_back(b);
        shadow_phase = PH_ESC;
      end else if (!(b == CH_DEL || (b < CH_SP && b != CH_LF && b != CH_TAB))) begin
        add_res(b, 1'b1, 1'b0, 1'b0);
      end
      return;
    end
    // overlong: buffer and this byte dropped, marker only
    if (shadow_seq.size() >= SEQ_DEPTH) begin
      shadow_seq.delete();
      shadow_phase = PH_GROUND;
      add_res(8'h00, 1'b0, 1'b0, 1'b1);
      return;
    end
    shadow_seq.push_back(b);
    case (shadow_phase)
      PH_ESC: begin
        if (b == CH_CSI) shadow_phase = PH_CSI;
        else if (b == CH_OSC) shadow_phase = PH_OSC;
        else if (b == CH_DCS || b == CH_SOS || b == CH_PM || b == CH_APC)
          shadow_phase = PH_STR;
        else if (b >= INT_LO && b <= INT_HI) shadow_phase = PH_INTER;
        else if (b >= FIN_LO && b <= FIN_HI) close_seq();
        else bad = 1'b1;
      end
      PH_CSI: begin
        if (b >= CSF_LO && b <= FIN_HI) close_seq();
        else if (!(b >= INT_LO && b <= PAR_HI)) bad = 1'b1;
      end
      PH_OSC: begin
        if (b == CH_BEL) close_seq();
        else if (b == CH_ESC) shadow_phase = PH_OSC_ESC;
      end
      PH_OSC_ESC: begin
        if (b == CH_ST || b == CH_BEL) close_seq();
        else if (b != CH_ESC) shadow_phase = PH_OSC;
      end
      PH_STR: begin
        if (b == CH_ESC) shadow_phase = PH_STR_ESC;
      end
      PH_STR_ESC: begin
        if (b == CH_ST) close_seq();
        else if (b != CH_ESC) shadow_phase = PH_STR;
      end
      PH_INTER: begin
        if (b >= FIN_LO && b <= FIN_HI) close_seq();
        else if (!(b >= INT_LO && b <= INT_HI)) bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
  endtask

  // Work out the output of one transaction and queue it.
  task automatic predict_text(input logic [7:0] b, input bit eot);
    logic [7:0] work[$];
    logic [7:0] x;
    bit bad;
    run_res.delete();
    if (!eot) work.push_back(b);
    forever begin
      while (work.size() > 0) begin
        x = work.pop_front();
        parse_byte(x, bad);
        if (bad) begin
          // drop the ESC, replay the rest in front of what is left
          for (int i = shadow_seq.size() - 1; i >= 1; i--) work.push_front(shadow_seq[i]);
          shadow_seq.delete();
          shadow_phase = PH_GROUND;
        end
      end
      if (!eot || shadow_phase == PH_GROUND) break;
      // end of text: unterminated sequence resolved like a malformed one
      for (int i = shadow_seq.size() - 1; i >= 1; i--) work.push_front(shadow_seq[i]);
      shadow_seq.delete();
      shadow_phase = PH_GROUND;
    end
    if (eot) add_res(8'h00, 1'b0, 1'b1, 1'b0);
    if (run_res.size() > 0) run_res[run_res.size() - 1].last = 1'b1;
    foreach (run_res[i]) clean_q.push_back(run_res[i]);
  endtask

  // ---------------------------------------------------------------- gaps
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------- driver
  int send_gap;
  always @(posedge clk) begin
    text_item_t it;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_text(in_ch.in_byte, in_ch.end_of_text);
        accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          it = text_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.in_byte <= it.data;
          in_ch.end_of_text <= it.eot;
          send_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int recv_gap;
  int hold_left;
  always @(posedge clk) begin
    clean_res_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (clean_q.size() == 0) begin
          $error("unexpected result: out_byte %h", out_ch.out_byte);
          errors++;
        end else begin
          e = clean_q.pop_front();
          if (out_ch.out_byte !== e.data) begin
            $error("out_byte: expected %h, actual %h", e.data, out_ch.out_byte);
            errors++;
          end
          if (out_ch.has_byte !== e.has) begin
            $error("has_byte: expected %b, actual %b", e.has, out_ch.has_byte);
            errors++;
          end
          if (out_ch.last_of_run !== e.last) begin
            $error("last_of_run: expected %b, actual %b", e.last, out_ch.last_of_run);
            errors++;
          end
          if (out_ch.text_end !== e.te) begin
            $error("text_end: expected %b, actual %b", e.te, out_ch.text_end);
            errors++;
          end
          if (out_ch.seq_overflow !== e.ov) begin
            $error("seq_overflow: expected %b, actual %b", e.ov, out_ch.seq_overflow);
            errors++;
          end
        end
      end
      // one long hold-off while the sender keeps offering
      if (!pressure_done && accepted >= 120) begin
        pressure_done = 1'b1;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic put(input logic [7:0] b, input bit eot = 1'b0);
    text_item_t it;
    it.data = b;
    it.eot = eot;
    text_q.push_back(it);
  endtask

  // random byte that is neither BEL nor ESC, for sequence bodies
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_BEL || b == CH_ESC);
    return b;
  endfunction

  task automatic gen_sequence();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      put(8'($urandom_range(0, 255)));
    end else if (kind < 45) begin                 // CSI
      put(CH_ESC); put(CH_CSI);
      n = $urandom_range(0, 4);
      repeat (n) put(8'($urandom_range(INT_LO, PAR_HI)));
      put(8'($urandom_range(CSF_LO, FIN_HI)));
    end else if (kind < 55) begin                 // OSC, BEL or ST terminated
      put(CH_ESC); put(CH_OSC);
      n = $urandom_range(0, 6);
      repeat (n) put(body_byte());
      if ($urandom_range(0, 1)) put(CH_BEL);
      else begin put(CH_ESC); put(CH_ST); end
    end else if (kind < 65) begin                 // DCS / SOS / PM / APC
      put(CH_ESC);
      case ($urandom_range(0, 3))
        0: put(CH_DCS);
        1: put(CH_SOS);
        2: put(CH_PM);
        default: put(CH_APC);
      endcase
      n = $urandom_range(0, 6);
      repeat (n) put(body_byte());
      if ($urandom_range(0, 3) == 0) put(CH_ESC);   // doubled ESC before ST
      put(CH_ESC); put(CH_ST);
    end else if (kind < 73) begin                 // plain escape with intermediates
      put(CH_ESC);
      n = $urandom_range(0, 3);
      repeat (n) put(8'($urandom_range(INT_LO, INT_HI)));
      put(8'($urandom_range(FIN_LO, FIN_HI)));
    end else if (kind < 85) begin                 // broken sequence, random tail
      put(CH_ESC);
      n = $urandom_range(0, 3);
      repeat (n) put(8'($urandom_range(0, 255)));
    end else if (kind < 90) begin                 // overlong OSC
      put(CH_ESC); put(CH_OSC);
      n = $urandom_range(SEQ_DEPTH - 2, SEQ_DEPTH + 3);
      repeat (n) put(body_byte());
    end else if (kind < 95) begin                 // sequence cut by end of text
      put(CH_ESC); put(CH_CSI); put(8'($urandom_range(INT_LO, PAR_HI)));
      put(8'h00, 1'b1);
    end else begin
      put(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic write_allow(input bit v);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.pass_seq <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    shadow_allow = v;
  endtask

  task automatic drain();
    while (text_q.size() > 0 || in_ch.valid || clean_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    accepted = 0;
    cycles = 0;
    no_gaps = 1'b0;
    pressure_done = 1'b0;
    shadow_phase = PH_GROUND;
    shadow_allow = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every sequence kind and the corner cases
    write_allow(1'b1);
    put(8'h41); put(8'h00); put(CH_TAB); put(CH_LF); put(CH_DEL); put(8'h1f); put(8'hff);
    put(CH_ESC); put(CH_CSI); put(8'h31); put(8'h6d);                 // CSI
    put(CH_ESC); put(CH_OSC); put(8'h00); put(CH_BEL);                 // OSC, zero as data
    put(CH_ESC); put(8'h28); put(8'h42);                               // intermediate + final
    put(CH_ESC); put(CH_DCS); put(CH_ESC); put(CH_ST);                 // string with ST
    put(CH_ESC); put(CH_CSI); put(8'h01);                              // broken CSI
    put(CH_ESC); put(8'h80);                                           // broken plain escape
    put(CH_ESC); put(CH_OSC); put(8'h61);
    put(8'h00, 1'b1);                                                  // unterminated at end
    drain();

    for (int p = 0; p < 4; p++) begin
      write_allow(p[0]);
      no_gaps = (p == 2);
      while (text_q.size() < 75) gen_sequence();
      put(8'h00, 1'b1);
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
